@@ sv/max_weight_assignment_solver_unit_defines.svh @@
// Assertion macros used by the assignment solver top level.
`ifndef MAX_WEIGHT_ASSIGNMENT_SOLVER_UNIT_DEFINES_SVH
`define MAX_WEIGHT_ASSIGNMENT_SOLVER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MWAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MWAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mwas_pkg.sv @@
// Constants, sequencer codes and interface structs of the assignment solver.
package mwas_pkg;

  localparam int MAX_N       = 16;
  localparam int IDX_W       = $clog2(MAX_N);
  localparam int CNT_W       = $clog2(MAX_N + 1);
  localparam int NN_W        = 2 * CNT_W;
  localparam int STORE_DEPTH = MAX_N * MAX_N;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WEIGHT_W    = 16;
  localparam int LABEL_W     = 32;
  localparam int RC_W        = LABEL_W + 2;
  localparam int SIZE_W      = 7;
  localparam int OUT_IDX_W   = 6;
  localparam int TOTAL_W     = 22;
  localparam int OP_W        = 4;

  localparam logic [SIZE_W-1:0]         RESET_SIZE = SIZE_W'(16);
  localparam logic signed [LABEL_W-1:0] INF_SLACK  = LABEL_W'(1073741823);

  // Sequencer steps; the controller state doubles as the datapath command.
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd0;
  localparam logic [OP_W-1:0] OP_INIT      = 4'd1;
  localparam logic [OP_W-1:0] OP_MAX_RD    = 4'd2;
  localparam logic [OP_W-1:0] OP_MAX_ACC   = 4'd3;
  localparam logic [OP_W-1:0] OP_ROOT_INIT = 4'd4;
  localparam logic [OP_W-1:0] OP_GROW_CHK  = 4'd5;
  localparam logic [OP_W-1:0] OP_GROW_EVAL = 4'd6;
  localparam logic [OP_W-1:0] OP_AUG       = 4'd7;
  localparam logic [OP_W-1:0] OP_RND_START = 4'd8;
  localparam logic [OP_W-1:0] OP_MIN       = 4'd9;
  localparam logic [OP_W-1:0] OP_UPD       = 4'd10;
  localparam logic [OP_W-1:0] OP_SCAN      = 4'd11;
  localparam logic [OP_W-1:0] OP_NEXT_ROOT = 4'd12;
  localparam logic [OP_W-1:0] OP_OUT_RD    = 4'd13;
  localparam logic [OP_W-1:0] OP_OUT_LATCH = 4'd14;
  localparam logic [OP_W-1:0] OP_OUT_WAIT  = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_fire;
    logic            out_fire;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic i_last;
    logic j_last;
    logic chk_end;
    logic sp_zero;
    logic chk_marked;
    logic eval_aug;
    logic aug_stop;
    logic scan_end;
    logic rounds_done;
    logic scan_hit;
    logic scan_free;
    logic root_last;
  } status_t;

endpackage

@@ sv/mwas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mwas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/mwas_ctrl.sv @@
// Sequencer of the assignment solver: load, solve and result phases.
module mwas_ctrl
  import mwas_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_ready_o,
  output logic    out_valid_o
);

  logic [OP_W-1:0] state_q, state_d;
  logic            ctx_q, ctx_d;  // set while a search runs from inside a label round

  assign in_ready_o    = (state_q == OP_LOAD);
  assign out_valid_o   = (state_q == OP_OUT_WAIT);
  assign cmd_o.op      = state_q;
  assign cmd_o.in_fire = in_ready_o && in_valid_i;
  assign cmd_o.out_fire = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    case (state_q)
      OP_LOAD: begin
        if (in_valid_i && status_i.load_last) state_d = OP_INIT;
      end
      OP_INIT:   state_d = OP_MAX_RD;
      OP_MAX_RD: state_d = OP_MAX_ACC;
      OP_MAX_ACC: begin
        state_d = (status_i.i_last && status_i.j_last) ? OP_ROOT_INIT : OP_MAX_RD;
      end
      OP_ROOT_INIT: begin
        ctx_d   = 1'b0;
        state_d = OP_GROW_CHK;
      end
      OP_GROW_CHK: begin
        if (status_i.chk_end) begin
          if (status_i.sp_zero) state_d = ctx_q ? OP_SCAN : OP_RND_START;
        end else if (!status_i.chk_marked) begin
          state_d = OP_GROW_EVAL;
        end
      end
      OP_GROW_EVAL: state_d = status_i.eval_aug ? OP_AUG : OP_GROW_CHK;
      OP_AUG: begin
        if (status_i.aug_stop) state_d = OP_NEXT_ROOT;
      end
      OP_RND_START: state_d = OP_MIN;
      OP_MIN: begin
        if (status_i.j_last) state_d = OP_UPD;
      end
      OP_UPD: begin
        if (status_i.j_last) state_d = OP_SCAN;
      end
      OP_SCAN: begin
        if (status_i.scan_end) begin
          state_d = status_i.rounds_done ? OP_NEXT_ROOT : OP_RND_START;
        end else if (status_i.scan_hit) begin
          if (status_i.scan_free) begin
            state_d = OP_AUG;
          end else begin
            ctx_d   = 1'b1;
            state_d = OP_GROW_CHK;
          end
        end
      end
      OP_NEXT_ROOT: state_d = status_i.root_last ? OP_OUT_RD : OP_ROOT_INIT;
      OP_OUT_RD:    state_d = OP_OUT_LATCH;
      OP_OUT_LATCH: state_d = OP_OUT_WAIT;
      OP_OUT_WAIT: begin
        if (out_ready_i) state_d = status_i.j_last ? OP_LOAD : OP_OUT_RD;
      end
      default: state_d = OP_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OP_LOAD;
      ctx_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
    end
  end

endmodule

@@ sv/mwas_dpath.sv @@
// Datapath of the assignment solver: weight store, labels, slacks, trees and results.
module mwas_dpath
  import mwas_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output status_t                     status_o,
  input  logic                        cfg_we_i,
  input  logic [SIZE_W-1:0]           cfg_wdata_i,
  input  logic signed [WEIGHT_W-1:0]  weight_i,
  output logic [OUT_IDX_W-1:0]        column_o,
  output logic [OUT_IDX_W-1:0]        matched_row_o,
  output logic signed [WEIGHT_W-1:0]  pair_weight_o,
  output logic signed [TOTAL_W-1:0]   running_total_o,
  output logic                        last_o
);

  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] load_cnt_q;

  logic signed [LABEL_W-1:0] row_label_q [MAX_N];
  logic signed [LABEL_W-1:0] col_label_q [MAX_N];
  logic signed [LABEL_W-1:0] slack_q     [MAX_N];
  logic [IDX_W-1:0]          row_col_q   [MAX_N];
  logic [IDX_W-1:0]          col_row_q   [MAX_N];
  logic [IDX_W-1:0]          match_row_q [MAX_N];
  logic [IDX_W-1:0]          par_q       [MAX_N];
  logic [IDX_W-1:0]          stk_row_q   [MAX_N];
  logic [CNT_W-1:0]          stk_col_q   [MAX_N];
  logic [MAX_N-1:0]          row_vis_q, row_root_q, col_vis_q, match_vld_q;

  logic [IDX_W-1:0] v_q, aug_c_q;
  logic [CNT_W-1:0] i_q, j_q, root_q, rounds_q, sp_q, aug_g_q;
  logic signed [LABEL_W-1:0] mn_q;
  logic signed [TOTAL_W-1:0] total_q;

  logic [OUT_IDX_W-1:0]       column_q, matched_row_q;
  logic signed [WEIGHT_W-1:0] pair_weight_q;
  logic signed [TOTAL_W-1:0]  running_total_q;
  logic                       last_q;

  logic [CNT_W-1:0]          n;
  logic [NN_W-1:0]           nn, cnt_inc, raddr_full;
  logic [IDX_W-1:0]          ci, ri, rm, mul_row, mul_col;
  logic [CNT_W-1:0]          sp_dec;
  logic [WEIGHT_W-1:0]       rdata;
  logic signed [WEIGHT_W-1:0] wt, pw_sel;
  logic signed [RC_W-1:0]    rc;
  logic signed [LABEL_W-1:0] m_new;
  logic signed [TOTAL_W-1:0] total_next;
  logic                      rc_zero, slack_gt, descend;

  // Size in use is the register clamped to 1..MAX_N.
  always_comb begin
    if (size_q == '0) begin
      n = CNT_W'(1);
    end else if (size_q > SIZE_W'(MAX_N)) begin
      n = CNT_W'(MAX_N);
    end else begin
      n = size_q[CNT_W-1:0];
    end
  end

  assign nn      = NN_W'(n) * NN_W'(n);
  assign cnt_inc = NN_W'(load_cnt_q) + NN_W'(1);
  assign sp_dec  = sp_q - CNT_W'(1);

  // One column index and one row index per array, chosen by the current step.
  always_comb begin
    case (cmd_i.op)
      OP_GROW_CHK, OP_GROW_EVAL: ci = i_q[IDX_W-1:0];
      OP_AUG:                    ci = aug_c_q;
      default:                   ci = j_q[IDX_W-1:0];
    endcase
    ri = (cmd_i.op == OP_GROW_EVAL) ? v_q : j_q[IDX_W-1:0];
    case (cmd_i.op)
      OP_AUG:  rm = col_row_q[ci];
      OP_UPD:  rm = j_q[IDX_W-1:0];
      default: rm = match_row_q[ci];
    endcase
    case (cmd_i.op)
      OP_GROW_CHK: begin
        mul_row = v_q;
        mul_col = i_q[IDX_W-1:0];
      end
      OP_MAX_RD: begin
        mul_row = j_q[IDX_W-1:0];
        mul_col = i_q[IDX_W-1:0];
      end
      default: begin
        mul_row = match_row_q[ci];
        mul_col = ci;
      end
    endcase
  end

  assign raddr_full = NN_W'(mul_row) * NN_W'(n) + NN_W'(mul_col);

  mwas_ram #(
    .WIDTH(WEIGHT_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.in_fire),
    .waddr_i(load_cnt_q),
    .wdata_i(weight_i),
    .raddr_i(raddr_full[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  assign wt         = $signed(rdata);
  assign rc         = RC_W'(row_label_q[ri]) + RC_W'(col_label_q[ci]) - RC_W'(wt);
  assign rc_zero    = (rc == '0);
  assign slack_gt   = RC_W'(slack_q[ci]) > rc;
  assign m_new      = (LABEL_W'(wt) > mn_q) ? LABEL_W'(wt) : mn_q;
  assign descend    = match_vld_q[ci] && !row_vis_q[rm] && (sp_q < CNT_W'(MAX_N));
  assign pw_sel     = match_vld_q[ci] ? wt : '0;
  assign total_next = total_q + TOTAL_W'(pw_sel);

  assign status_o.load_last   = cnt_inc >= nn;
  assign status_o.i_last      = (i_q + CNT_W'(1)) == n;
  assign status_o.j_last      = (j_q + CNT_W'(1)) == n;
  assign status_o.chk_end     = i_q >= n;
  assign status_o.sp_zero     = (sp_q == '0);
  assign status_o.chk_marked  = col_vis_q[ci];
  assign status_o.eval_aug    = rc_zero && !match_vld_q[ci];
  assign status_o.aug_stop    = !col_vis_q[ci] || !row_vis_q[rm] || row_root_q[rm] ||
                                (aug_g_q == n);
  assign status_o.scan_end    = (j_q == n);
  assign status_o.rounds_done = (rounds_q == n);
  assign status_o.scan_hit    = !col_vis_q[ci] && (slack_q[ci] == '0);
  assign status_o.scan_free   = !match_vld_q[ci];
  assign status_o.root_last   = (root_q + CNT_W'(1)) == n;

  // Control state: counters, pointers and the tree and match flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= RESET_SIZE;
      load_cnt_q  <= '0;
      row_vis_q   <= '0;
      row_root_q  <= '0;
      col_vis_q   <= '0;
      match_vld_q <= '0;
      v_q         <= '0;
      aug_c_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      root_q      <= '0;
      rounds_q    <= '0;
      sp_q        <= '0;
      aug_g_q     <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          if (cmd_i.in_fire) begin
            load_cnt_q <= status_o.load_last ? '0 : cnt_inc[ADDR_W-1:0];
          end
        end
        OP_INIT: begin
          match_vld_q <= '0;
          i_q         <= '0;
          j_q         <= '0;
          root_q      <= '0;
        end
        OP_MAX_ACC: begin
          if (status_o.i_last) begin
            i_q <= '0;
            j_q <= j_q + CNT_W'(1);
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        OP_ROOT_INIT: begin
          row_vis_q  <= MAX_N'(1) << root_q[IDX_W-1:0];
          row_root_q <= MAX_N'(1) << root_q[IDX_W-1:0];
          col_vis_q  <= '0;
          v_q        <= root_q[IDX_W-1:0];
          i_q        <= '0;
          sp_q       <= '0;
          rounds_q   <= '0;
        end
        OP_GROW_CHK: begin
          if (status_o.chk_end) begin
            if (!status_o.sp_zero) begin
              sp_q <= sp_dec;
              v_q  <= stk_row_q[sp_dec[IDX_W-1:0]];
              i_q  <= stk_col_q[sp_dec[IDX_W-1:0]];
            end
          end else if (col_vis_q[ci]) begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        OP_GROW_EVAL: begin
          i_q <= i_q + CNT_W'(1);
          if (rc_zero) begin
            col_vis_q[ci] <= 1'b1;
            if (!match_vld_q[ci]) begin
              aug_c_q <= ci;
              aug_g_q <= '0;
            end else if (descend) begin
              row_vis_q[rm]  <= 1'b1;
              row_root_q[rm] <= 1'b0;
              sp_q           <= sp_q + CNT_W'(1);
              v_q            <= rm;
              i_q            <= '0;
            end
          end
        end
        OP_AUG: begin
          if (col_vis_q[ci]) begin
            match_vld_q[ci] <= 1'b1;
            aug_c_q         <= row_col_q[rm];
            aug_g_q         <= aug_g_q + CNT_W'(1);
          end
        end
        OP_RND_START: j_q <= '0;
        OP_MIN, OP_UPD: j_q <= status_o.j_last ? '0 : j_q + CNT_W'(1);
        OP_SCAN: begin
          if (status_o.scan_end) begin
            rounds_q <= rounds_q + CNT_W'(1);
          end else begin
            j_q <= j_q + CNT_W'(1);
            if (status_o.scan_hit) begin
              col_vis_q[ci] <= 1'b1;
              if (match_vld_q[ci]) begin
                row_vis_q[rm]  <= 1'b1;
                row_root_q[rm] <= 1'b0;
                v_q            <= rm;
                i_q            <= '0;
                sp_q           <= '0;
              end else begin
                aug_c_q <= ci;
                aug_g_q <= '0;
              end
            end
          end
        end
        OP_NEXT_ROOT: begin
          root_q <= root_q + CNT_W'(1);
          j_q    <= '0;
        end
        OP_OUT_WAIT: begin
          if (cmd_i.out_fire) j_q <= j_q + CNT_W'(1);
        end
        default: ;
      endcase
      if (cfg_we_i) begin
        size_q     <= cfg_wdata_i;
        load_cnt_q <= '0;
      end
    end
  end

  // Payload state: labels, slacks, tree links, stack and result registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_INIT: begin
        for (int k = 0; k < MAX_N; k++) begin
          col_label_q[k] <= '0;
        end
        mn_q    <= '0;
        total_q <= '0;
      end
      OP_MAX_ACC: begin
        if (status_o.i_last) begin
          row_label_q[ri] <= m_new;
          mn_q            <= '0;
        end else begin
          mn_q <= m_new;
        end
      end
      OP_ROOT_INIT: begin
        for (int k = 0; k < MAX_N; k++) begin
          slack_q[k] <= INF_SLACK;
        end
      end
      OP_GROW_EVAL: begin
        if (slack_gt) begin
          slack_q[ci] <= rc[LABEL_W-1:0];
          par_q[ci]   <= v_q;
        end
        if (rc_zero) begin
          col_row_q[ci] <= v_q;
          if (descend) begin
            row_col_q[rm]                <= ci;
            stk_row_q[sp_q[IDX_W-1:0]] <= v_q;
            stk_col_q[sp_q[IDX_W-1:0]] <= i_q + CNT_W'(1);
          end
        end
      end
      OP_AUG: begin
        if (col_vis_q[ci]) match_row_q[ci] <= col_row_q[ci];
      end
      OP_RND_START: mn_q <= INF_SLACK;
      OP_MIN: begin
        if (!col_vis_q[ci] && (slack_q[ci] < mn_q)) mn_q <= slack_q[ci];
      end
      OP_UPD: begin
        if (row_vis_q[ri]) row_label_q[ri] <= row_label_q[ri] - mn_q;
        if (col_vis_q[ci]) begin
          col_label_q[ci] <= col_label_q[ci] + mn_q;
        end else begin
          slack_q[ci] <= slack_q[ci] - mn_q;
        end
      end
      OP_SCAN: begin
        if (!status_o.scan_end && status_o.scan_hit) begin
          col_row_q[ci] <= par_q[ci];
          if (match_vld_q[ci]) row_col_q[rm] <= ci;
        end
      end
      OP_OUT_LATCH: begin
        column_q        <= OUT_IDX_W'(j_q);
        matched_row_q   <= match_vld_q[ci] ? OUT_IDX_W'(match_row_q[ci]) : '0;
        pair_weight_q   <= pw_sel;
        running_total_q <= total_next;
        total_q         <= total_next;
        last_q          <= status_o.j_last;
      end
      default: ;
    endcase
  end

  assign column_o        = column_q;
  assign matched_row_o   = matched_row_q;
  assign pair_weight_o   = pair_weight_q;
  assign running_total_o = running_total_q;
  assign last_o          = last_q;

endmodule

@@ sv/max_weight_assignment_solver_unit.sv @@
// Top level of the maximum-weight assignment solver.
//
// The block takes a square weight matrix on the input channel, one signed
// weight per request in row-major order, at one request per cycle. The size
// in use comes from the matrix_size register (cfg_we_i / cfg_wdata_i), which
// is clamped to 1..16; writing it restarts the load at row 0, column 0.
// After the request that carries the last weight, the input channel closes
// and the solver runs the slack-form Kuhn-Munkres method. Its length depends
// on the data: the row maxima read every weight once, and each tree search
// and label round visits the columns one at a time, so a solve is bounded by
// the single weight store read port and the one-column-per-cycle label and
// slack updates. Results then leave on the output channel in column order,
// each read from the store, latched and then shown, the last one flagged
// with last_o and carrying the complete total.
// A stalled receiver simply holds the current result; nothing is lost.
// After the last result is taken, the input channel opens again on the next
// cycle. Reset selects size 16, clears the load position and the matching
// state, and leaves the block waiting for the first weight.
module max_weight_assignment_solver_unit
  import mwas_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [SIZE_W-1:0]           cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [WEIGHT_W-1:0]  weight_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [OUT_IDX_W-1:0]        column_o,
  output logic [OUT_IDX_W-1:0]        matched_row_o,
  output logic signed [WEIGHT_W-1:0]  pair_weight_o,
  output logic signed [TOTAL_W-1:0]   running_total_o,
  output logic                        last_o
);

  `include "max_weight_assignment_solver_unit_defines.svh"

  cmd_t    cmd;
  status_t status;

  // The controller walks the solve steps; the datapath carries them out.
  mwas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o)
  );

  mwas_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .weight_i       (weight_i),
    .column_o       (column_o),
    .matched_row_o  (matched_row_o),
    .pair_weight_o  (pair_weight_o),
    .running_total_o(running_total_o),
    .last_o         (last_o)
  );

  // Loading and result delivery never overlap.
  `MWAS_ASSERT_SAME(a_no_overlap, out_valid_o, !in_ready_o, "input open while a result is shown")
  // Taking the final result reopens the input channel at once.
  `MWAS_ASSERT_NEXT(a_load_after_last, out_valid_o && out_ready_i && last_o, in_ready_o, "input not reopened after final result")
  // Between two results the next one is still being read and latched.
  `MWAS_ASSERT_NEXT(a_result_gap, out_valid_o && out_ready_i && !last_o, !out_valid_o, "result shown without a fresh read")

endmodule
